### rtl/core/rk4_photon_orbit_integrator_top_assert.svh
// Assertion macros for the photon orbit integrator checker.
// Depends on nothing; included by the checker file only.
`ifndef RK4_PHOTON_ORBIT_INTEGRATOR_TOP_ASSERT_SVH
`define RK4_PHOTON_ORBIT_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define RK4PO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rk4po check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define RK4PO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rk4po check failed");

`endif

### rtl/core/rk4po_pkg.sv
// Shared types, constants and helpers for the photon orbit integrator.
// No dependencies.
`timescale 1ns / 1ps

package rk4po_pkg;

  localparam int VAL_W     = 48;
  localparam int SUM_W     = 52;
  localparam int H_W       = 37;
  localparam int RS_W      = 47;
  localparam int CNT_W     = 14;
  localparam int DNUM_W    = 63;
  localparam int DDEN_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 47;

  localparam logic signed [VAL_W-1:0] VAL_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN   = 48'sh8000_0000_0000;
  localparam logic signed [VAL_W-1:0] FAR_LIMIT = 48'sd6553600000000;

  localparam logic [H_W-1:0]  STEP_RST = 37'd68719477;
  localparam logic [RS_W-1:0] RS_RST   = 47'd68719476736;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RS   = 2'd1;

  localparam logic [1:0] REASON_ALL  = 2'd0;
  localparam logic [1:0] REASON_CAPT = 2'd1;
  localparam logic [1:0] REASON_ESC  = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] u_start;
    logic signed [VAL_W-1:0] slope_start;
    logic [CNT_W-1:0]        step_count;
  } rk4po_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] radius;
    logic signed [VAL_W-1:0] u_final;
    logic signed [VAL_W-1:0] slope_final;
    logic [CNT_W-1:0]        steps_done;
    logic [1:0]              stop_reason;
  } rk4po_out_t;

  // micro-operations of one RK4 step
  typedef enum logic [2:0] {
    UOP_SQ, UOP_KV, UOP_KP, UOP_DIVU, UOP_DIVV, UOP_DIVR
  } rk4po_uop_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INIT, ST_INITW, ST_ISSUE, ST_WAIT, ST_CHECK, ST_OUT
  } rk4po_state_e;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic       div_go;
    logic       init;
    rk4po_uop_e uop;
    logic [1:0] stage;
  } rk4po_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic n_zero;
    logic finished;
  } rk4po_sts_t;

  // saturate a wide signed sum to 48 bits
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > SUM_W'(VAL_MAX))      r = VAL_MAX;
    else if (x < SUM_W'(VAL_MIN)) r = VAL_MIN;
    else                          r = x[VAL_W-1:0];
    return r;
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [VAL_W-1:0] half_tz(input logic signed [VAL_W-1:0] x);
    logic signed [VAL_W:0] t;
    t = (VAL_W+1)'(x) + $signed({{VAL_W{1'b0}}, x[VAL_W-1]});
    return t[VAL_W:1];
  endfunction

  function automatic logic [VAL_W-1:0] mag_val(input logic signed [VAL_W-1:0] x);
    return x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
  endfunction

endpackage

### rtl/core/rk4po_mul.sv
// Signed Q-format multiplier: four 24x24 partial products, then round and saturate.
// Depends on rk4po_pkg.
`timescale 1ns / 1ps

module rk4po_mul import rk4po_pkg::*; #(
  parameter int FRAC_BITS = 36
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  logic signed [VAL_W-1:0] a_i,
  input  logic signed [VAL_W-1:0] b_i,
  output logic                    done_o,
  output logic signed [VAL_W-1:0] res_o
);

  localparam int HW = VAL_W / 2;
  localparam int PW = 2 * VAL_W;

  logic             run_q, fin_q, done_q;
  logic [1:0]       cnt_q;
  logic [VAL_W-1:0] ma_q, mb_q;
  logic             neg_q;
  logic [PW-1:0]    acc_q;
  logic signed [VAL_W-1:0] res_q;

  logic [VAL_W-1:0] pp;
  logic [PW-1:0]    pp_sh;
  logic [PW:0]      rnd;
  logic [PW:0]      m;
  logic signed [VAL_W-1:0] res_d;

  // partial product for the current pass
  always_comb begin
    pp = (cnt_q[0] ? ma_q[VAL_W-1:HW] : ma_q[HW-1:0]) *
         (cnt_q[1] ? mb_q[VAL_W-1:HW] : mb_q[HW-1:0]);
    case (cnt_q)
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * HW);
      default: pp_sh = PW'(pp) << HW;
    endcase
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    rnd = (PW+1)'(acc_q) + ((PW+1)'(1) << (FRAC_BITS - 1));
    m   = rnd >> FRAC_BITS;
    if (neg_q) res_d = (m > (PW+1)'(49'h1_0000_0000_0000 >> 1)) ? VAL_MIN
                                                                : -$signed(m[VAL_W-1:0]);
    else       res_d = (m > (PW+1)'(VAL_MAX)) ? VAL_MAX : $signed(m[VAL_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator datapath
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      ma_q  <= mag_val(a_i);
      mb_q  <= mag_val(b_i);
      neg_q <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### rtl/core/rk4po_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on rk4po_pkg.
`timescale 1ns / 1ps

module rk4po_div import rk4po_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [DNUM_W-1:0] num_i,
  input  logic [DDEN_W-1:0] den_i,
  output logic              done_o,
  output logic [DNUM_W-1:0] quo_o
);

  logic              run_q, done_q;
  logic [5:0]        cnt_q;
  logic [DDEN_W:0]   rem_q;
  logic [DNUM_W-1:0] quo_q;
  logic [DDEN_W-1:0] den_q;

  logic [DDEN_W:0] trial;
  logic            fits;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem_q[DDEN_W-1:0], quo_q[DNUM_W-1]};
    fits  = trial >= (DDEN_W+1)'(den_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DNUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= fits ? trial - (DDEN_W+1)'(den_q) : trial;
      quo_q <= {quo_q[DNUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/rk4po_datapath.sv
// Datapath: orbit state, RK4 accumulators, config registers, shared mul,
// radius divider and divide-by-six unit.
// Depends on rk4po_pkg, rk4po_mul, rk4po_div.
`timescale 1ns / 1ps

module rk4po_datapath import rk4po_pkg::*; #(
  parameter int MAX_STEPS = 8192,
  parameter int FRAC_BITS = 36
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rk4po_cmd_t           cmd_i,
  output rk4po_sts_t           sts_o,
  input  rk4po_in_t            in_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output rk4po_out_t           res_o
);

  localparam int          D6_W     = 56;
  localparam int          D6_STEPS = 7;
  localparam logic [10:0] D6_RECIP = 11'd1366;  // ceil(2^13 / 6)

  logic [H_W-1:0]  h_q;
  logic [RS_W-1:0] rs_q;
  logic signed [VAL_W-1:0] u_q, v_q, k_q, kp_q, a_q, r_q;
  logic signed [SUM_W-1:0] su_q, sv_q;
  logic [CNT_W-1:0] n_q, cnt_q;
  logic [1:0]       reason_q;

  logic signed [VAL_W-1:0] opu, opv, ma, mb, prod, acc_a, r_new;
  logic signed [SUM_W-1:0] k_add, su_next, sv_next, qs;
  logic signed [VAL_W+2:0] t3;
  logic                    mul_done, div_done, rdiv_done, rdiv_go;
  logic [DNUM_W-1:0]       dnum, quo;
  logic [DDEN_W-1:0]       dden;
  logic signed [VAL_W:0]   rs16;
  logic [1:0]              reason_new;

  logic [SUM_W-1:0] d6_mag;
  logic             d6_go, d6_run_q, d6_done_q;
  logic [2:0]       d6_cnt_q, d6_rem_q, d6_rem;
  logic [D6_W-1:0]  d6_num_q, d6_quo_q;
  logic [10:0]      d6_v;
  logic [21:0]      d6_p;
  logic [7:0]       d6_dq;

  // stage offset added to u or v: none, half, or full k
  function automatic logic signed [VAL_W-1:0] koff(input logic [1:0] st,
                                                   input logic signed [VAL_W-1:0] k);
    logic signed [VAL_W-1:0] r;
    case (st)
      2'd0:    r = '0;
      2'd3:    r = k;
      default: r = half_tz(k);
    endcase
    return r;
  endfunction

  assign opu = sat_val(SUM_W'(u_q) + SUM_W'(koff(cmd_i.stage, k_q)));
  assign opv = sat_val(SUM_W'(v_q) + SUM_W'(koff(cmd_i.stage, kp_q)));

  // multiplier operand select
  always_comb begin
    case (cmd_i.uop)
      UOP_SQ:  begin ma = opu; mb = opu; end
      UOP_KV:  begin ma = opv; mb = $signed(VAL_W'(h_q)); end
      default: begin ma = a_q; mb = $signed(VAL_W'(h_q)); end
    endcase
  end

  rk4po_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni, .go_i(cmd_i.mul_go), .a_i(ma), .b_i(mb),
    .done_o(mul_done), .res_o(prod)
  );

  // radius divider: rs * 2^16 over |u|
  assign dnum    = {rs_q, 16'b0};
  assign dden    = mag_val(u_q);
  assign rdiv_go = cmd_i.div_go && (cmd_i.uop == UOP_DIVR);

  rk4po_div u_div (
    .clk_i, .rst_ni, .go_i(rdiv_go), .num_i(dnum), .den_i(dden),
    .done_o(rdiv_done), .quo_o(quo)
  );

  // divide-by-six unit: one byte of the magnitude per cycle, reciprocal
  // multiply for the byte quotient, remainder carried into the next byte
  assign d6_go = cmd_i.div_go && (cmd_i.uop == UOP_DIVU || cmd_i.uop == UOP_DIVV);

  always_comb begin
    d6_mag = (cmd_i.uop == UOP_DIVV) ? (sv_q[SUM_W-1] ? SUM_W'(-sv_q) : SUM_W'(sv_q))
                                     : (su_q[SUM_W-1] ? SUM_W'(-su_q) : SUM_W'(su_q));
    d6_v   = {d6_rem_q, d6_num_q[D6_W-1 -: 8]};
    d6_p   = 22'(d6_v) * 22'(D6_RECIP);
    d6_dq  = 8'(d6_p >> 13);
    d6_rem = 3'(d6_v - 11'(d6_dq) * 11'd6);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d6_run_q  <= 1'b0;
      d6_done_q <= 1'b0;
      d6_cnt_q  <= '0;
    end else begin
      d6_done_q <= 1'b0;
      if (d6_go) begin
        d6_run_q <= 1'b1;
        d6_cnt_q <= '0;
      end else if (d6_run_q) begin
        d6_cnt_q <= d6_cnt_q + 3'd1;
        if (d6_cnt_q == 3'(D6_STEPS - 1)) begin
          d6_run_q  <= 1'b0;
          d6_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (d6_go) begin
      d6_num_q <= D6_W'(d6_mag);
      d6_rem_q <= '0;
    end else if (d6_run_q) begin
      d6_num_q <= d6_num_q << 8;
      d6_rem_q <= d6_rem;
      d6_quo_q <= {d6_quo_q[D6_W-9:0], d6_dq};
    end
  end

  assign div_done = rdiv_done | d6_done_q;

  // f(u) = 3u^2/2 - u from the square
  always_comb begin
    t3    = (VAL_W+3)'(prod) + ((VAL_W+3)'(prod) <<< 1) + (VAL_W+3)'(1);
    acc_a = sat_val(SUM_W'(t3[VAL_W+2:1]) - SUM_W'(opu));
  end

  // weighted k sums: weights 1, 2, 2, 1
  always_comb begin
    k_add = (cmd_i.stage == 2'd1 || cmd_i.stage == 2'd2) ? (SUM_W'(prod) <<< 1)
                                                          : SUM_W'(prod);
    su_next = (cmd_i.stage == 2'd0) ? k_add : su_q + k_add;
    sv_next = (cmd_i.stage == 2'd0) ? k_add : sv_q + k_add;
  end

  // signed quotient of the sum over six
  always_comb begin
    qs = $signed(SUM_W'(d6_quo_q[VAL_W-1:0]));
    if ((cmd_i.uop == UOP_DIVU && su_q[SUM_W-1]) ||
        (cmd_i.uop == UOP_DIVV && sv_q[SUM_W-1])) qs = -qs;
  end

  // radius from the quotient, then the stop test
  always_comb begin
    if (u_q == '0)
      r_new = VAL_MAX;
    else if (!u_q[VAL_W-1])
      r_new = (quo > DNUM_W'(VAL_MAX)) ? VAL_MAX : $signed(quo[VAL_W-1:0]);
    else
      r_new = (quo > (DNUM_W'(1) << (VAL_W - 1))) ? VAL_MIN : -$signed(quo[VAL_W-1:0]);
    rs16 = $signed({2'b00, rs_q >> (FRAC_BITS - 16)});
    if ((VAL_W+1)'(r_new) < rs16) reason_new = REASON_CAPT;
    else if (r_new > FAR_LIMIT)   reason_new = REASON_ESC;
    else                          reason_new = REASON_ALL;
  end

  // config registers and step bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q      <= STEP_RST;
      rs_q     <= RS_RST;
      cnt_q    <= '0;
      n_q      <= '0;
      reason_q <= REASON_ALL;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STEP: h_q  <= cfg_data_i[H_W-1:0];
          CFG_RS:   rs_q <= cfg_data_i[RS_W-1:0];
          default:  ;
        endcase
      end
      if (cmd_i.load) begin
        cnt_q    <= '0;
        reason_q <= REASON_ALL;
        n_q      <= (17'(in_i.step_count) > 17'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
                                                            : in_i.step_count;
      end else if (div_done && cmd_i.uop == UOP_DIVR && !cmd_i.init) begin
        cnt_q    <= cnt_q + CNT_W'(1);
        reason_q <= reason_new;
      end
    end
  end

  // orbit state writeback
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_q <= in_i.u_start;
      v_q <= in_i.slope_start;
    end
    if (mul_done) begin
      case (cmd_i.uop)
        UOP_SQ:  a_q <= acc_a;
        UOP_KV:  begin k_q <= prod; su_q <= su_next; end
        default: begin kp_q <= prod; sv_q <= sv_next; end
      endcase
    end
    if (div_done) begin
      case (cmd_i.uop)
        UOP_DIVU: u_q <= sat_val(SUM_W'(u_q) + qs);
        UOP_DIVV: v_q <= sat_val(SUM_W'(v_q) + qs);
        default:  r_q <= r_new;
      endcase
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.finished = (cnt_q == n_q) || (reason_q != REASON_ALL);

  assign res_o.radius      = r_q;
  assign res_o.u_final     = u_q;
  assign res_o.slope_final = v_q;
  assign res_o.steps_done  = cnt_q;
  assign res_o.stop_reason = reason_q;

endmodule

### rtl/core/rk4po_ctrl.sv
// Controller: sequences the twelve multiplies and three divisions of each RK4 step.
// Depends on rk4po_pkg.
`timescale 1ns / 1ps

module rk4po_ctrl import rk4po_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       done_o,
  input  rk4po_sts_t sts_i,
  output rk4po_cmd_t cmd_o
);

  rk4po_state_e state_q, state_d;
  rk4po_uop_e   uop_q, uop_d;
  logic [1:0]   stage_q, stage_d;
  logic         is_mul, unit_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      uop_q   <= UOP_SQ;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      uop_q   <= uop_d;
      stage_q <= stage_d;
    end
  end

  assign is_mul    = (uop_q == UOP_SQ) || (uop_q == UOP_KV) || (uop_q == UOP_KP);
  assign unit_done = is_mul ? sts_i.mul_done : sts_i.div_done;

  // next state and commands
  always_comb begin
    state_d = state_q;
    uop_d   = uop_q;
    stage_d = stage_q;
    cmd_o   = '0;
    cmd_o.uop   = uop_q;
    cmd_o.stage = stage_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          uop_d      = UOP_DIVR;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init   = 1'b1;
        cmd_o.div_go = 1'b1;
        state_d      = ST_INITW;
      end
      ST_INITW: begin
        cmd_o.init = 1'b1;
        if (sts_i.div_done) begin
          uop_d   = UOP_SQ;
          stage_d = '0;
          state_d = sts_i.n_zero ? ST_OUT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.mul_go = is_mul;
        cmd_o.div_go = !is_mul;
        state_d      = ST_WAIT;
      end
      ST_WAIT: begin
        if (unit_done) begin
          state_d = ST_ISSUE;
          unique case (uop_q)
            UOP_SQ: uop_d = UOP_KV;
            UOP_KV: uop_d = UOP_KP;
            UOP_KP: begin
              if (stage_q == 2'd3) uop_d = UOP_DIVU;
              else begin
                uop_d   = UOP_SQ;
                stage_d = stage_q + 2'd1;
              end
            end
            UOP_DIVU: uop_d = UOP_DIVV;
            UOP_DIVV: uop_d = UOP_DIVR;
            default:  state_d = ST_CHECK;
          endcase
        end
      end
      ST_CHECK: begin
        uop_d   = UOP_SQ;
        stage_d = '0;
        state_d = sts_i.finished ? ST_OUT : ST_ISSUE;
      end
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_OUT);

endmodule

### rtl/core/rk4_photon_orbit_integrator_top.sv
// Channel   Handshake            Payload
// input     start_i / busy_o     in_i  (rk4po_in_t)
// result    done_o strobe        res_o (rk4po_out_t)
// config    cfg_we_i             cfg_idx_i, cfg_data_i
//
// One item at a time. Each RK4 step runs twelve multiplies on the shared four-pass
// 24x24 multiplier, two divide-by-six passes, one radius division on the bit-serial
// divider and a check state. busy_o drops after done_o.
// done_o is high for one cycle with res_o valid; the receiver cannot stall it.
// Reset puts the config registers to their defaults and returns the block to idle.
//
// Top level of the photon orbit integrator.
// Depends on rk4po_pkg, rk4po_ctrl, rk4po_datapath.
`timescale 1ns / 1ps

module rk4_photon_orbit_integrator_top import rk4po_pkg::*; #(
  parameter int MAX_STEPS = 8192,
  parameter int FRAC_BITS = 36
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  rk4po_in_t            in_i,
  output logic                 done_o,
  output rk4po_out_t           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  rk4po_cmd_t cmd;
  rk4po_sts_t sts;

  rk4po_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  rk4po_datapath #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .res_o
  );

endmodule

### rtl/core/rk4po_checker.sv
// Port-level checks for the photon orbit integrator, bound to the top level.
// Depends on rk4po_pkg and rk4_photon_orbit_integrator_top_assert.svh.
`timescale 1ns / 1ps
`include "rk4_photon_orbit_integrator_top_assert.svh"

module rk4po_port_sva import rk4po_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_i,
  input logic       done_i,
  input rk4po_out_t res_i
);

  // a result beat only comes out of a running item
  `RK4PO_ASSERT_NOW(a_done_busy, done_i, busy_i)
  // an accepted item makes the block busy
  `RK4PO_ASSERT_NEXT(a_start_busy, start_i && !busy_i, busy_i)
  // after the result beat the block is free again
  `RK4PO_ASSERT_NEXT(a_done_idle, done_i, !busy_i)
  // stop reason is one of the three codes
  `RK4PO_ASSERT_NOW(a_reason, done_i, res_i.stop_reason <= REASON_ESC)

endmodule

bind rk4_photon_orbit_integrator_top rk4po_port_sva u_rk4po_port_sva (
  .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .done_i(done_o), .res_i(res_o)
);

### tb/rk4po_checker.sv
// Checker for the photon orbit integrator: mirrors the config registers,
// predicts one result per accepted beat and compares it with res_o.
// Depends on rk4po_pkg.
`timescale 1ns / 1ps

module rk4po_checker import rk4po_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  rk4po_in_t            in_i,
  input  logic                 done_i,
  input  rk4po_out_t           res_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int  MAX_STEPS = 8192;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam longint FAR_R  = 64'sd6553600000000;

  logic [H_W-1:0]  dtheta;
  logic [RS_W-1:0] rs_q;
  rk4po_out_t      orbit_q[$];

  function automatic longint clip48(input longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  function automatic longint unsigned absval(input longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  // Q12.36 product, rounded half away from zero, saturated
  function automatic longint qmul(input longint a, input longint b);
    logic [127:0] p;
    logic [127:0] m;
    p = 128'(absval(a)) * 128'(absval(b)) + (128'd1 << 35);
    m = p >> 36;
    if ((a < 0) != (b < 0)) return (m > (128'd1 << 47)) ? SAT_LO : -longint'(m);
    return (m > 128'(SAT_HI)) ? SAT_HI : longint'(m);
  endfunction

  // orbit equation right-hand side: 1.5u^2 - u
  function automatic longint orbit_acc(input longint u);
    longint uu;
    uu = qmul(u, u);
    return clip48(((3 * uu + 1) >>> 1) - u);
  endfunction

  function automatic longint radius_from_u(input longint u);
    longint unsigned num;
    longint unsigned q;
    num = longint'(rs_q) << 16;
    if (u == 0) return SAT_HI;
    q = num / absval(u);
    if (u > 0) return (q > SAT_HI) ? SAT_HI : longint'(q);
    return (q > (64'd1 << 47)) ? SAT_LO : -longint'(q);
  endfunction

  function automatic rk4po_out_t integrate_orbit(input rk4po_in_t beat);
    rk4po_out_t o;
    longint u, v, h, r, rs16, n, cnt;
    longint k1, k2, k3, k4, p1, p2, p3, p4;
    logic [1:0] why;
    u = longint'(beat.u_start);
    v = longint'(beat.slope_start);
    n = longint'(beat.step_count);
    h = longint'(dtheta);
    rs16 = longint'(rs_q >> 20);
    r = radius_from_u(u);
    cnt = 0;
    why = REASON_ALL;
    if (n > MAX_STEPS) n = MAX_STEPS;
    while (cnt < n) begin
      k1 = qmul(v, h);
      p1 = qmul(orbit_acc(u), h);
      k2 = qmul(clip48(v + p1 / 2), h);
      p2 = qmul(orbit_acc(clip48(u + k1 / 2)), h);
      k3 = qmul(clip48(v + p2 / 2), h);
      p3 = qmul(orbit_acc(clip48(u + k2 / 2)), h);
      k4 = qmul(clip48(v + p3), h);
      p4 = qmul(orbit_acc(clip48(u + k3)), h);
      u = clip48(u + (k1 + 2 * k2 + 2 * k3 + k4) / 6);
      v = clip48(v + (p1 + 2 * p2 + 2 * p3 + p4) / 6);
      cnt++;
      r = radius_from_u(u);
      if (r < rs16) begin
        why = REASON_CAPT;
        break;
      end
      if (r > FAR_R) begin
        why = REASON_ESC;
        break;
      end
    end
    o.radius      = r[VAL_W-1:0];
    o.u_final     = u[VAL_W-1:0];
    o.slope_final = v[VAL_W-1:0];
    o.steps_done  = cnt[CNT_W-1:0];
    o.stop_reason = why;
    return o;
  endfunction

  assign pending_o = orbit_q.size();

  // config mirror, predict on accept, compare on strobe
  always @(posedge clk_i or negedge rst_ni) begin
    rk4po_out_t exp_r;
    if (!rst_ni) begin
      dtheta <= STEP_RST;
      rs_q   <= RS_RST;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_STEP) dtheta <= cfg_data_i[H_W-1:0];
      if (cfg_we_i && cfg_idx_i == CFG_RS)   rs_q   <= cfg_data_i[RS_W-1:0];
      if (start_i && !busy_i) orbit_q.push_back(integrate_orbit(in_i));
      if (done_i) begin
        if (orbit_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result beat %h", res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = orbit_q.pop_front();
          if (exp_r !== res_i) begin
            if (fail_count_o < 10)
              $display("mismatch r %h/%h u %h/%h v %h/%h n %0d/%0d why %0d/%0d",
                exp_r.radius, res_i.radius, exp_r.u_final, res_i.u_final,
                exp_r.slope_final, res_i.slope_final, exp_r.steps_done,
                res_i.steps_done, exp_r.stop_reason, res_i.stop_reason);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top for the photon orbit integrator: clock, reset, config
// phases and input beats; rk4po_checker does prediction and compare.
// Depends on rk4po_pkg, rk4_photon_orbit_integrator_top, rk4po_checker.
`timescale 1ns / 1ps

module tb_top;
  import rk4po_pkg::*;

  localparam int  WATCHDOG = 6000000;
  localparam logic signed [VAL_W-1:0] ONE_Q = 48'sd68719476736;

  logic                 clk, rst_n, start, busy, done, cfg_we;
  rk4po_in_t            beat_in;
  rk4po_out_t           res;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;
  int                   fails, pending, quiet;
  int                   idle_pct;

  rk4_photon_orbit_integrator_top uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .in_i(beat_in),
    .done_o(done), .res_o(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  rk4po_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .in_i(beat_in),
    .done_i(done), .res_i(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .fail_count_o(fails), .pending_o(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog on cycles without any accepted beat or result strobe
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet > WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_orbit(input logic [VAL_W-1:0] u, input logic [VAL_W-1:0] v,
                            input logic [CNT_W-1:0] n);
    logic free;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start   <= 1'b1;
    beat_in <= '{u_start: u, slope_start: v, step_count: n};
    forever begin
      free = !busy;
      @(posedge clk);
      if (free) break;
      @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // random orbit beat, mostly physical starting points
  task automatic random_orbit();
    logic [VAL_W-1:0] u, v;
    logic [CNT_W-1:0] n;
    n = 14'($urandom_range(40));
    case ($urandom_range(9))
      0, 1: begin
        u = rand48();
        v = rand48();
        n = 14'($urandom_range(6));
      end
      2: begin
        u = -$signed(48'($urandom_range(1 << 30)) << 6);
        v = rand48();
        n = ($urandom_range(3) == 0) ? 14'(14'h3FFF - $urandom_range(100))
                                     : 14'($urandom_range(60));
      end
      default: begin
        u = 48'($urandom_range(32'h6000_0000)) << 5;
        v = 48'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000) << 5;
      end
    endcase
    send_orbit(u, v, n);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    beat_in = '0;
    idle_pct = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: zero steps, zero u, capture, step count extremes
    send_orbit('0, '0, 14'd0);
    send_orbit('0, '0, 14'h3FFF);
    send_orbit(-ONE_Q, '0, 14'd8192);
    send_orbit(VAL_MAX, VAL_MIN, 14'd3);
    send_orbit(VAL_MIN, VAL_MAX, 14'd3);
    send_orbit(ONE_Q >>> 1, ONE_Q >>> 4, 14'd20);
    send_orbit(48'sd45812984490, '0, 14'd30);
    send_orbit(48'sd1, '0, 14'd2);
    send_orbit(48'sd700, -48'sd1, 14'd4);
    send_orbit(ONE_Q, ONE_Q, 14'd10);
    send_orbit(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 14'h2AAA);
    send_orbit(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 14'h1555);

    // register extremes, indexes past the list are ignored
    write_reg(CFG_STEP, 47'h1F_FFFF_FFFF);
    write_reg(CFG_RS, '1);
    write_reg(2'd2, '0);
    write_reg(2'd3, '0);
    send_orbit(ONE_Q >>> 1, ONE_Q >>> 2, 14'd5);
    send_orbit(rand48(), rand48(), 14'd5);
    write_reg(CFG_STEP, 47'd1);
    write_reg(CFG_RS, 47'd1);
    send_orbit(ONE_Q, '0, 14'd5);
    send_orbit(48'sd3, '0, 14'd5);
    write_reg(CFG_RS, '0);
    send_orbit(ONE_Q, '0, 14'd2);
    send_orbit(-ONE_Q, '0, 14'd2);

    // random phases, each with its own config, some with sender idling
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) begin
        write_reg(CFG_STEP, STEP_RST);
        write_reg(CFG_RS, RS_RST);
      end else begin
        write_reg(CFG_STEP, ($urandom_range(1)) ? 47'($urandom_range(1 << 30))
                                                 : 47'({$urandom, $urandom}));
        write_reg(CFG_RS, ($urandom_range(1)) ? 47'(RS_RST) << $urandom_range(3)
                                               : 47'({$urandom, $urandom}));
      end
      idle_pct = (ph == 1) ? 65 : (ph == 3) ? 31 : 0;
      for (int k = 0; k < 16; k++) begin
        random_orbit();
        if (k == 8) drain();
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
